>>> src/stack_bytecode_cpu_step_macros.svh
// Assertion macros for the stack bytecode core.
`ifndef STACK_BYTECODE_CPU_STEP_MACROS_SVH
`define STACK_BYTECODE_CPU_STEP_MACROS_SVH
`ifndef ASSERT_OFF
`define SBC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SBC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SBC_ASSERT(label, clk, rst, prop)
`define SBC_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> src/sbc_pkg.sv
// Shared types and constants for the stack bytecode core.
package sbc_pkg;
  localparam int OPERAND_DEPTH = 64;
  localparam int CALL_DEPTH = 256;
  localparam int PC_BITS = 16;
  localparam int OW = $clog2(OPERAND_DEPTH);
  localparam int CW = $clog2(CALL_DEPTH);
  localparam logic [PC_BITS-1:0] OP_LEN = PC_BITS'(1);
  localparam logic [PC_BITS-1:0] OPK_LEN = PC_BITS'(5);

  typedef enum logic [3:0] {
    EFF_NONE = 4'd0, EFF_SETUP = 4'd1, EFF_WRITE = 4'd2, EFF_DMS = 4'd3,
    EFF_DUS = 4'd4, EFF_PEEK = 4'd5, EFF_PRINT = 4'd6, EFF_HALT = 4'd7,
    EFF_INVALID = 4'd8, EFF_BOUNDS = 4'd9
  } effect_t;

  typedef enum logic [7:0] {
    OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MUL = 8'd2, OP_OR = 8'd20, OP_XOR = 8'd21,
    OP_AND = 8'd22, OP_NOT = 8'd23, OP_NEG = 8'd24, OP_SHL = 8'd25, OP_SHR = 8'd26,
    OP_BOOL = 8'd27, OP_LNOT = 8'd28, OP_JMP = 8'd40, OP_ALLOC = 8'd41,
    OP_CALL = 8'd42, OP_RET = 8'd43, OP_EQ = 8'd44, OP_NE = 8'd45, OP_GT = 8'd46,
    OP_LT = 8'd47, OP_GE = 8'd48, OP_LE = 8'd49, OP_JNZ = 8'd50, OP_JZ = 8'd51,
    OP_PUSH = 8'd60, OP_SPILL = 8'd61, OP_LOAD = 8'd62, OP_STORE = 8'd63,
    OP_POP = 8'd64, OP_PSETUP = 8'd80, OP_PREAD = 8'd81, OP_PWRITE = 8'd82,
    OP_DMS = 8'd100, OP_DUS = 8'd101, OP_HALT = 8'd200, OP_NOP = 8'd201,
    OP_PEEK = 8'd202, OP_PRINT = 8'd203
  } opcode_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] immediate;
    logic [31:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [3:0]  effect;
    logic [31:0] effect_pin;
    logic [31:0] effect_value;
    logic        halted;
  } out_item_t;

  // front-end classification that travels with each request
  typedef struct packed {
    logic        known;
    logic        takes_imm;
    logic [7:0]  opcode;
    logic [31:0] immediate;
    logic [31:0] pin_levels;
  } dec_item_t;

  function automatic logic op_known(input logic [7:0] op);
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_XOR, OP_AND, OP_NOT, OP_NEG, OP_SHL,
      OP_SHR, OP_BOOL, OP_LNOT, OP_JMP, OP_ALLOC, OP_CALL, OP_RET, OP_EQ, OP_NE,
      OP_GT, OP_LT, OP_GE, OP_LE, OP_JNZ, OP_JZ, OP_PUSH, OP_SPILL, OP_LOAD,
      OP_STORE, OP_POP, OP_PSETUP, OP_PREAD, OP_PWRITE, OP_DMS, OP_DUS,
      OP_HALT, OP_NOP, OP_PEEK, OP_PRINT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
endpackage

>>> src/sbc_front.sv
// Front end: decode each request into a two-entry queue.
module sbc_front import sbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      dq_valid,
  input  logic      dq_take,
  output dec_item_t dq_item
);
  dec_item_t slots [2];
  logic rd;
  logic [1:0] count;
  dec_item_t dec;
  logic take_in;

  assign full = count[1];
  assign take_in = push && !full;
  assign dq_valid = count != 2'd0;
  assign dq_item = slots[rd];

  always_comb begin
    dec.opcode = item.opcode;
    dec.immediate = item.immediate;
    dec.pin_levels = item.pin_levels;
    dec.known = op_known(item.opcode);
    dec.takes_imm = (item.opcode == OP_JMP) || (item.opcode == OP_ALLOC) ||
      (item.opcode == OP_CALL) || (item.opcode == OP_RET) || (item.opcode == OP_JNZ) ||
      (item.opcode == OP_JZ) || (item.opcode == OP_PUSH) || (item.opcode == OP_LOAD) ||
      (item.opcode == OP_STORE) || (item.opcode == OP_NOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      count <= 2'd0;
    end else begin
      if (dq_valid && dq_take) rd <= ~rd;
      count <= count + 2'(take_in) - 2'(dq_valid && dq_take);
    end
    if (take_in) slots[rd ^ count[0]] <= dec;
  end
endmodule

>>> src/sbc_ram.sv
// Generic single-port-write, one-read RAM with registered read.
module sbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/sbc_back.sv
// Back end: execute one decoded request.
module sbc_back import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] program_size,
  input  logic        dq_valid,
  output logic        dq_take,
  input  dec_item_t   dq_item,
  output logic        res_valid,
  input  logic        res_take,
  output out_item_t   res_item
);
  typedef enum logic [1:0] {ST_CLEAR, ST_FETCH, ST_EXEC} bstate_t;
  bstate_t state, state_next;

  logic [31:0] b_top;
  logic [31:0] a_below;
  logic [31:0] call_rd;
  logic [31:0] call_rd2;
  logic [OW-1:0] otop, below;
  logic [CW-1:0] ctop, fbase;
  logic [PC_BITS-1:0] pc;
  logic stopped;
  logic [CW:0] clr;

  // the operand stack is held in two RAM copies, one read at the top, one just below it
  logic [OW-1:0] o_raddr_a, o_raddr_b, o_waddr;
  logic o_we_a;
  logic [31:0] o_wdata;
  logic c_we;
  logic [CW-1:0] c_waddr, c_raddr, c_raddr2;
  logic [31:0] c_wdata;

  logic out_free;
  out_item_t res;
  logic [31:0] ra, rb, rk;
  logic [7:0] op;

  assign op = dq_item.opcode;
  assign rk = dq_item.immediate;
  assign below = otop - OW'(1);
  assign out_free = !res_valid || res_take;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr[CW]) state_next = ST_FETCH;
      ST_FETCH: if (dq_valid) state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_FETCH;
      default:  state_next = ST_FETCH;
    endcase
  end

  // both stacks get two read ports by duplicating each RAM
  assign o_raddr_a = below;
  assign o_raddr_b = otop;
  assign c_raddr = (op == OP_RET) ? fbase : fbase + rk[CW-1:0];
  assign c_raddr2 = fbase - CW'(1);

  sbc_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_oa (
    .clk, .we(o_we_a), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr_a),
    .rdata(ra));
  sbc_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_ob (
    .clk, .we(o_we_a), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr_b),
    .rdata(rb));
  sbc_ram #(.WIDTH(32), .DEPTH(CALL_DEPTH)) u_c1 (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr),
    .rdata(call_rd));
  sbc_ram #(.WIDTH(32), .DEPTH(CALL_DEPTH)) u_c2 (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr2),
    .rdata(call_rd2));

  assign a_below = ra;
  assign b_top = rb;

  logic exec;
  logic [31:0] r;
  logic [OW-1:0] otop_next;
  logic [CW-1:0] ctop_next, fbase_next, ctop1;
  logic [PC_BITS-1:0] pc_next, seq, seqk, kpc;
  logic stop_next;
  logic clearing;

  assign exec = (state == ST_EXEC) && out_free;
  assign dq_take = exec;
  assign clearing = (state == ST_CLEAR);
  assign seq = pc + OP_LEN;
  assign seqk = pc + OPK_LEN;
  assign kpc = rk[PC_BITS-1:0];
  assign ctop1 = ctop + CW'(1);

  always_comb begin
    r = '0;
    otop_next = otop;
    ctop_next = ctop;
    fbase_next = fbase;
    pc_next = pc;
    stop_next = stopped;
    o_we_a = 1'b0;
    o_waddr = otop;
    o_wdata = '0;
    c_we = 1'b0;
    c_waddr = ctop1;
    c_wdata = '0;
    res = '0;
    if (stopped) begin
      res.effect = EFF_NONE;
    end else if (32'(pc) > 32'(program_size)) begin
      res.effect = EFF_BOUNDS;
      stop_next = 1'b1;
    end else begin
      case (op)
        OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_XOR, OP_AND, OP_SHL, OP_SHR, OP_EQ,
        OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
          case (op)
            OP_ADD: r = a_below + b_top;
            OP_SUB: r = a_below - b_top;
            OP_MUL: r = a_below * b_top;
            OP_OR:  r = a_below | b_top;
            OP_XOR: r = a_below ^ b_top;
            OP_AND: r = a_below & b_top;
            OP_SHL: r = (b_top >= 32'd32) ? '0 : a_below << b_top[4:0];
            OP_SHR: r = (b_top >= 32'd32) ? '0 : a_below >> b_top[4:0];
            OP_EQ:  r = 32'(a_below == b_top);
            OP_NE:  r = 32'(a_below != b_top);
            OP_GT:  r = 32'(a_below > b_top);
            OP_LT:  r = 32'(a_below < b_top);
            OP_GE:  r = 32'(a_below >= b_top);
            default: r = 32'(a_below <= b_top);
          endcase
          otop_next = below; o_we_a = 1'b1; o_waddr = below; o_wdata = r;
          pc_next = seq;
        end
        OP_NOT:  begin o_we_a = 1'b1; o_wdata = ~b_top; pc_next = seq; end
        OP_NEG:  begin o_we_a = 1'b1; o_wdata = 32'd0 - b_top; pc_next = seq; end
        OP_BOOL: begin o_we_a = 1'b1; o_wdata = 32'(b_top != 0); pc_next = seq; end
        OP_LNOT: begin o_we_a = 1'b1; o_wdata = 32'(b_top == 0); pc_next = seq; end
        OP_JMP:  pc_next = kpc;
        OP_ALLOC: begin
          c_we = 1'b1; c_wdata = 32'(fbase);
          fbase_next = ctop1; ctop_next = ctop1 + rk[CW-1:0]; pc_next = seqk;
        end
        OP_CALL: begin
          c_we = 1'b1; c_wdata = 32'(seqk) | (32'(pc) + 32'd5 & ~32'(seqk));
          c_wdata = 32'(pc) + 32'd5;
          ctop_next = ctop1; pc_next = kpc;
        end
        OP_RET: begin
          fbase_next = call_rd[CW-1:0];
          ctop_next = fbase - CW'(2) - rk[CW-1:0];
          pc_next = call_rd2[PC_BITS-1:0];
        end
        OP_JNZ: begin pc_next = (b_top != 0) ? kpc : seqk; otop_next = below; end
        OP_JZ:  begin pc_next = (b_top == 0) ? kpc : seqk; otop_next = below; end
        OP_PUSH: begin
          otop_next = otop + OW'(1); o_we_a = 1'b1; o_waddr = otop + OW'(1);
          o_wdata = rk; pc_next = seqk;
        end
        OP_SPILL: begin
          c_we = 1'b1; c_wdata = b_top; ctop_next = ctop1; otop_next = below;
          pc_next = seq;
        end
        OP_LOAD: begin
          otop_next = otop + OW'(1); o_we_a = 1'b1; o_waddr = otop + OW'(1);
          o_wdata = call_rd; pc_next = seqk;
        end
        OP_STORE: begin
          c_we = 1'b1; c_waddr = fbase + rk[CW-1:0]; c_wdata = b_top;
          otop_next = below; pc_next = seqk;
        end
        OP_POP: begin otop_next = below; pc_next = seq; end
        OP_PSETUP: begin
          otop_next = otop - OW'(2); res.effect = EFF_SETUP;
          res.effect_pin = a_below; res.effect_value = b_top; pc_next = seq;
        end
        OP_PREAD: begin
          o_we_a = 1'b1;
          o_wdata = (b_top < 32'd32) ? 32'(dq_item.pin_levels[b_top[4:0]]) : '0;
          pc_next = seq;
        end
        OP_PWRITE: begin
          otop_next = below; res.effect = EFF_WRITE;
          res.effect_pin = a_below; res.effect_value = b_top; pc_next = seq;
        end
        OP_DMS: begin
          res.effect = EFF_DMS; res.effect_value = b_top; otop_next = below;
          pc_next = seq;
        end
        OP_DUS: begin
          res.effect = EFF_DUS; res.effect_value = b_top; otop_next = below;
          pc_next = seq;
        end
        OP_HALT: begin res.effect = EFF_HALT; stop_next = 1'b1; end
        OP_NOP:  pc_next = seqk;
        OP_PEEK: begin res.effect = EFF_PEEK; res.effect_value = b_top; pc_next = seq; end
        OP_PRINT: begin
          res.effect = EFF_PRINT; res.effect_value = b_top; otop_next = below;
          pc_next = seq;
        end
        default: begin
          res.effect = EFF_INVALID; res.effect_value = 32'(op); stop_next = 1'b1;
        end
      endcase
    end
    res.next_pc = 16'(pc_next);
    res.halted = stop_next;
    // zero both stacks after reset, one entry per cycle
    if (clearing) begin
      o_we_a = !clr[CW] && (clr < (CW+1)'(OPERAND_DEPTH));
      o_waddr = clr[OW-1:0];
      o_wdata = '0;
      c_we = !clr[CW];
      c_waddr = clr[CW-1:0];
      c_wdata = '0;
    end else if (!exec) begin
      o_we_a = 1'b0;
      c_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      otop <= '1;
      ctop <= '1;
      fbase <= '0;
      pc <= '0;
      stopped <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing && !clr[CW]) clr <= clr + (CW+1)'(1);
      if (exec) begin
        otop <= otop_next;
        ctop <= ctop_next;
        fbase <= fbase_next;
        pc <= pc_next;
        stopped <= stop_next;
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
    if (exec) res_item <= res;
  end
endmodule

>>> src/stack_bytecode_cpu_step.sv
// Top level of the stack bytecode core: front decoder, queue and executor.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  request  | push / full       | in_item  (opcode, immediate, pin_levels)
//  result   | pop / empty       | out_item (next_pc, effect, pin, value, halted)
//  config   | cfg_we            | cfg_data (program_size)
//
// The executor handles each instruction in a fetch state, which reads both
// stack RAMs (registered read), then an execute state that executes and
// writes back. The front queue holds two decoded requests, so new requests
// are taken while one executes. After reset the executor zeroes the stacks,
// one entry a cycle, before it takes a request.
// A result waits in the output register; a stalled pop holds the executor.
`include "stack_bytecode_cpu_step_macros.svh"
module stack_bytecode_cpu_step import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  logic [15:0] program_size;
  logic dq_valid, dq_take, res_valid;
  dec_item_t dq_item;

  // hold the ROM bound; write only while idle
  always_ff @(posedge clk) begin
    if (rst) program_size <= 16'hFFFF;
    else if (cfg_we) program_size <= cfg_data;
  end

  sbc_front u_front (
    .clk, .rst, .push, .full, .item(in_item),
    .dq_valid, .dq_take, .dq_item
  );

  sbc_back u_back (
    .clk, .rst, .program_size, .dq_valid, .dq_take, .dq_item,
    .res_valid, .res_take(pop), .res_item(out_item)
  );

  assign empty = !res_valid;

  `SBC_ASSERT(a_take_needs_valid, clk, rst, dq_take |-> dq_valid)
  `SBC_ASSERT(a_pop_drains, clk, rst, (pop && !empty && !dq_take) |=> empty)
  `SBC_ASSERT(a_halt_sticks, clk, rst,
    (!empty && out_item.halted && dq_take) |=> out_item.halted)
endmodule
